FILE: rtl/lhb_pkg.sv
// ----------------------------------------------------------------------------
// lhb_pkg
// Shared types and constants of the hierarchical Lagrange basis evaluator.
// ----------------------------------------------------------------------------
package lhb_pkg;

  localparam int IDX_W  = 6;    // table index and order
  localparam int VAL_W  = 32;   // Q2.30 node and point
  localparam int OUT_W  = 48;   // Q16.32 result
  localparam int MAG_W  = 47;   // running magnitude
  localparam int DIFF_W = 33;   // Q3.30 difference magnitude
  localparam int QUO_W  = 65;   // Q.32 quotient magnitude
  localparam int SUM_W  = 112;  // full product of magnitude and quotient
  localparam int FRAC_W = 32;

  localparam logic [MAG_W-1:0] ONE_Q32 = MAG_W'(64'h1_0000_0000);
  localparam logic [MAG_W-1:0] MAX_MAG = {MAG_W{1'b1}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_ZERO_DEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             sat;
  } mul_res_t;

endpackage

FILE: rtl/lhb_if.sv
// ----------------------------------------------------------------------------
// lhb_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lhb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [lhb_pkg::IDX_W-1:0]   entry_index;
  logic signed [lhb_pkg::VAL_W-1:0] entry_value;
  logic [lhb_pkg::IDX_W-1:0]   order;
  logic signed [lhb_pkg::VAL_W-1:0] point;

  modport source (
    output valid, command, entry_index, entry_value, order, point,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_value, order, point,
    output ready
  );
endinterface

interface lhb_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lhb_pkg::OUT_W-1:0] basis_value;
  logic [1:0]                       status;

  modport source (output valid, basis_value, status, input ready);
  modport sink (input valid, basis_value, status, output ready);
endinterface

FILE: rtl/lhb_node_mem.sv
// ----------------------------------------------------------------------------
// lhb_node_mem
// Node table: one write port, one registered read port; positions beyond
// the table depth are dropped on write and read as zero.
// ----------------------------------------------------------------------------
module lhb_node_mem #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [lhb_pkg::IDX_W-1:0]        wr_index,
  input  logic [lhb_pkg::VAL_W-1:0]        wr_data,
  input  logic [lhb_pkg::IDX_W-1:0]        rd_index,
  output logic [lhb_pkg::VAL_W-1:0]        rd_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int LIM_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (lhb_pkg::IDX_W > LIM_W) ? lhb_pkg::IDX_W : LIM_W;

  logic [lhb_pkg::VAL_W-1:0] mem [TABLE_DEPTH];
  logic [lhb_pkg::VAL_W-1:0] rd_q;
  logic                      rd_ok;
  logic [CMP_W-1:0]          wr_wide;
  logic [CMP_W-1:0]          rd_wide;
  logic                      wr_in;
  logic                      rd_in;

  assign wr_wide = CMP_W'(wr_index);
  assign rd_wide = CMP_W'(rd_index);
  assign wr_in   = wr_wide < CMP_W'(TABLE_DEPTH);
  assign rd_in   = rd_wide < CMP_W'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in) begin
      mem[wr_wide[ADDR_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q  <= mem[rd_wide[ADDR_W-1:0]];
    rd_ok <= rd_in;
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

FILE: rtl/lhb_div.sv
// ----------------------------------------------------------------------------
// lhb_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^32 / den).
// ----------------------------------------------------------------------------
module lhb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lhb_pkg::DIFF_W-1:0]    num,
  input  logic [lhb_pkg::DIFF_W-1:0]    den,
  output logic                          done,
  output logic [lhb_pkg::QUO_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(lhb_pkg::QUO_W);

  logic [lhb_pkg::QUO_W-1:0]  dvd;
  logic [lhb_pkg::DIFF_W-1:0] den_reg;
  logic [lhb_pkg::DIFF_W-1:0] rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [lhb_pkg::DIFF_W:0]   trial;
  logic [lhb_pkg::DIFF_W:0]   diff;
  logic                       take;

  assign trial = {rem, dvd[lhb_pkg::QUO_W-1]};
  assign take  = trial >= {1'b0, den_reg};
  assign diff  = trial - {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(lhb_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= {num, {lhb_pkg::FRAC_W{1'b0}}};
      den_reg <= den;
      rem     <= '0;
    end else if (busy) begin
      rem <= take ? diff[lhb_pkg::DIFF_W-1:0] : trial[lhb_pkg::DIFF_W-1:0];
      dvd <= {dvd[lhb_pkg::QUO_W-2:0], take};
    end
  end

  assign quotient = dvd;

endmodule

FILE: rtl/lhb_mul.sv
// ----------------------------------------------------------------------------
// lhb_mul
// Magnitude times quotient through one 32x32 multiplier over four partial
// products, then shift by 32 and clamp to the Q16.32 range.
// ----------------------------------------------------------------------------
module lhb_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lhb_pkg::MAG_W-1:0]  a,
  input  logic [lhb_pkg::QUO_W-1:0]  b,
  output logic                       done,
  output lhb_pkg::mul_res_t          res
);

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } shift_t;

  localparam int SAT_B = lhb_pkg::MAG_W + lhb_pkg::FRAC_W;

  logic [lhb_pkg::MAG_W-1:0] a_reg;
  logic [lhb_pkg::QUO_W-1:0] b_reg;
  logic [2:0]                cnt;
  logic                      busy;
  logic [63:0]               prod;
  shift_t                    psel;
  logic                      pvalid;
  logic [lhb_pkg::SUM_W-1:0] sum;
  logic [31:0]               opa;
  logic [31:0]               opb;
  shift_t                    sel;
  logic [lhb_pkg::SUM_W-1:0] addend;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        opa = a_reg[31:0];
        opb = b_reg[31:0];
        sel = SH_0;
      end
      2'd1: begin
        opa = a_reg[31:0];
        opb = b_reg[63:32];
        sel = SH_32;
      end
      2'd2: begin
        opa = 32'(a_reg[lhb_pkg::MAG_W-1:32]);
        opb = b_reg[31:0];
        sel = SH_32;
      end
      default: begin
        opa = 32'(a_reg[lhb_pkg::MAG_W-1:32]);
        opb = b_reg[63:32];
        sel = SH_64;
      end
    endcase
  end

  always_comb begin
    case (psel)
      SH_0:    addend = {48'd0, prod};
      SH_32:   addend = {16'd0, prod, 32'd0};
      default: addend = {prod[47:0], 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pvalid <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        pvalid <= 1'b0;
        cnt    <= '0;
      end else if (busy) begin
        if (!cnt[2]) begin
          pvalid <= 1'b1;
          cnt    <= cnt + 1'b1;
        end else begin
          pvalid <= 1'b0;
          busy   <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      sum   <= b[lhb_pkg::QUO_W-1] ? {1'b0, a, 64'd0} : '0;
    end else begin
      if (busy && !cnt[2]) begin
        prod <= opa * opb;
        psel <= sel;
      end
      if (pvalid) begin
        sum <= sum + addend;
      end
    end
  end

  always_comb begin
    res.sat = |sum[lhb_pkg::SUM_W-1:SAT_B];
    res.mag = res.sat ? lhb_pkg::MAX_MAG : sum[SAT_B-1:lhb_pkg::FRAC_W];
  end

endmodule

FILE: rtl/leja_hierarchical_basis_eval.sv
// ----------------------------------------------------------------------------
// leja_hierarchical_basis_eval
// Node table plus hierarchical Lagrange basis evaluation in fixed point.
// ----------------------------------------------------------------------------
// A load command writes one Q2.30 node and returns zero with status ok. An
// evaluate command of order k computes the product over i < k of
// (t - x[i]) / (x[k] - x[i]) in Q16.32 with one shared radix-2 divider
// (65 iterations) and one 32x32 multiplier, both used once per lower node,
// and stops early at the first equal pair of nodes. The input is taken only
// while the sequencer is idle; a finished result sits in the output register
// until it is transferred, and the next command can already be accepted
// meanwhile.
module leja_hierarchical_basis_eval #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  lhb_in_if.sink    req,
  lhb_out_if.source rsp
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LDK  = 7'b0000010,
    S_RDI  = 7'b0000100,
    S_LDI  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [lhb_pkg::VAL_W-1:0]  t_reg;
  logic [lhb_pkg::VAL_W-1:0]  xk;
  logic [lhb_pkg::IDX_W-1:0]  k_reg;
  logic [lhb_pkg::IDX_W-1:0]  i_reg;
  logic [lhb_pkg::MAG_W-1:0]  acc;
  logic                       neg;
  logic                       sat;
  logic                       zden;
  logic                       out_valid;
  logic [lhb_pkg::OUT_W-1:0]  out_value;
  logic [1:0]                 out_status;

  logic                       accept;
  logic                       wr_en;
  logic [lhb_pkg::IDX_W-1:0]  rd_index;
  logic [lhb_pkg::VAL_W-1:0]  rd_data;
  logic signed [lhb_pkg::DIFF_W-1:0] n_val;
  logic signed [lhb_pkg::DIFF_W-1:0] d_val;
  logic [lhb_pkg::DIFF_W-1:0] n_mag;
  logic [lhb_pkg::DIFF_W-1:0] d_mag;
  logic                       d_zero;
  logic                       div_start;
  logic                       div_done;
  logic [lhb_pkg::QUO_W-1:0]  quotient;
  logic                       mul_done;
  lhb_pkg::mul_res_t          mres;
  logic                       out_free;
  logic [lhb_pkg::OUT_W-1:0]  mag_ext;
  logic [lhb_pkg::OUT_W-1:0]  value_next;
  logic [1:0]                 status_next;
  logic [lhb_pkg::IDX_W-1:0]  i_inc;

  function automatic logic [lhb_pkg::DIFF_W-1:0] DIFF_MAG(
    input logic [lhb_pkg::DIFF_W-1:0] v
  );
    return ~v + 1'b1;
  endfunction

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign wr_en    = accept && (req.command == lhb_pkg::CMD_LOAD);
  assign rd_index = (state == S_IDLE) ? req.order : i_reg;
  assign out_free = !out_valid || rsp.ready;
  assign i_inc    = i_reg + 1'b1;

  lhb_node_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_index (req.entry_index),
    .wr_data  (req.entry_value),
    .rd_index (rd_index),
    .rd_data  (rd_data)
  );

  assign n_val  = $signed({t_reg[lhb_pkg::VAL_W-1], t_reg})
                - $signed({rd_data[lhb_pkg::VAL_W-1], rd_data});
  assign d_val  = $signed({xk[lhb_pkg::VAL_W-1], xk})
                - $signed({rd_data[lhb_pkg::VAL_W-1], rd_data});
  assign n_mag  = n_val[lhb_pkg::DIFF_W-1] ? DIFF_MAG(n_val) : n_val;
  assign d_mag  = d_val[lhb_pkg::DIFF_W-1] ? DIFF_MAG(d_val) : d_val;
  assign d_zero = (d_val == '0);

  assign div_start = (state == S_LDI) && !d_zero;

  lhb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (n_mag),
    .den      (d_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  lhb_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (div_done),
    .a     (acc),
    .b     (quotient),
    .done  (mul_done),
    .res   (mres)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.command == lhb_pkg::CMD_LOAD) ? S_DONE : S_LDK;
        end
      end
      S_LDK: begin
        state_next = (k_reg == '0) ? S_DONE : S_LDI;
      end
      S_RDI: state_next = S_LDI;
      S_LDI: state_next = d_zero ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = (i_inc == k_reg) ? S_DONE : S_RDI;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          t_reg <= req.point;
          k_reg <= req.order;
          i_reg <= '0;
          neg   <= 1'b0;
          sat   <= 1'b0;
          zden  <= 1'b0;
          acc   <= (req.command == lhb_pkg::CMD_LOAD) ? '0 : lhb_pkg::ONE_Q32;
        end
      end
      S_LDK: xk <= rd_data;
      S_LDI: begin
        if (d_zero) begin
          zden <= 1'b1;
        end else if (n_val[lhb_pkg::DIFF_W-1] != d_val[lhb_pkg::DIFF_W-1]) begin
          neg <= !neg;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          acc   <= mres.mag;
          sat   <= sat | mres.sat;
          i_reg <= i_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign mag_ext = {1'b0, acc};

  always_comb begin
    if (zden) begin
      value_next  = '0;
      status_next = lhb_pkg::ST_ZERO_DEN;
    end else begin
      value_next  = neg ? (~mag_ext + 1'b1) : mag_ext;
      status_next = sat ? lhb_pkg::ST_SAT : lhb_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_value  <= value_next;
      out_status <= status_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.basis_value = out_value;
  assign rsp.status      = out_status;

endmodule

FILE: rtl/lhb_checker.sv
// ----------------------------------------------------------------------------
// lhb_checker
// Port-level checks of the result channel of the basis evaluator.
// ----------------------------------------------------------------------------
module lhb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lhb_pkg::OUT_W-1:0] basis_value,
  input logic [1:0]                status
);

  localparam logic [lhb_pkg::OUT_W-1:0] MIN_VAL = {1'b1, {lhb_pkg::MAG_W{1'b0}}};

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == lhb_pkg::ST_OK || status == lhb_pkg::ST_SAT
                   || status == lhb_pkg::ST_ZERO_DEN))
    else $error("undefined status code");

  a_zero_den_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == lhb_pkg::ST_ZERO_DEN) |-> (basis_value == '0))
    else $error("zero denominator with nonzero value");

  a_no_min_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (basis_value != MIN_VAL))
    else $error("result at the most negative value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready)
      |=> (out_valid && $stable(basis_value) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind leja_hierarchical_basis_eval lhb_checker u_lhb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .basis_value (rsp.basis_value),
  .status      (rsp.status)
);
